/* src/gso_pkg.sv */
// Shared types, codes and helpers for the Gram-Schmidt orthonormaliser.
// Used by gso_root and the top level; no dependencies.
package gso_pkg;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_FILL,
    ST_SQ_RD,
    ST_SQ_WT,
    ST_ROOT,
    ST_NRM_RD,
    ST_NRM_WT,
    ST_DOT_RD,
    ST_DOT_WT,
    ST_UPD_RD,
    ST_UPD_WT,
    ST_OUT_RD,
    ST_OUT_WT
  } gso_state_t;

  // Operation of the shared root / divide unit
  typedef enum logic {
    OP_SQRT,
    OP_DIV
  } gso_op_t;

  // Configuration register indexes
  localparam logic [0:0] CFG_ROWS = 1'b0;
  localparam logic [0:0] CFG_COLS = 1'b1;

  // Quotient of a 7-bit count below 64 by a row count of 1 to 8,
  // by reciprocal multiplication
  function automatic logic [6:0] div_small(input logic [6:0] n, input logic [3:0] d);
    logic [16:0] p;
    logic [6:0]  q;
    p = 17'd0;
    q = n;
    unique case (d)
      4'd1: q = n;
      4'd2: q = {1'b0, n[6:1]};
      4'd3: begin
        p = 17'(n) * 17'd171;
        q = p[15:9];
      end
      4'd4: q = {2'b0, n[6:2]};
      4'd5: begin
        p = 17'(n) * 17'd205;
        q = p[16:10];
      end
      4'd6: begin
        p = 17'(n) * 17'd171;
        q = p[16:10];
      end
      4'd7: begin
        p = 17'(n) * 17'd147;
        q = p[16:10];
      end
      4'd8: q = {3'b0, n[6:3]};
      default: q = n;
    endcase
    return q;
  endfunction

endpackage

/* src/gso_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module gso_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and read with a registered output; hold data when not reading
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/gso_mul.sv */
// Iterative 52 x 48 bit signed-magnitude multiplier, four partial products.
// No dependencies.
module gso_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [51:0]  a_mag,
  input  logic [47:0]  b_mag,
  input  logic         neg,
  output logic         done,
  output logic [99:0]  prod
);

  logic        busy;
  logic [2:0]  step;
  logic [51:0] a_q;
  logic [47:0] b_q;
  logic        neg_q;
  logic [49:0] pp;
  logic [5:0]  sh_q;
  logic [99:0] acc_q;
  logic [25:0] a_part;
  logic [23:0] b_part;
  logic [5:0]  shift;

  // Pick the operand halves for this step
  always_comb begin
    a_part = step[0] ? a_q[51:26] : a_q[25:0];
    b_part = step[1] ? b_q[47:24] : b_q[23:0];
    shift  = (step[0] ? 6'd26 : 6'd0) + (step[1] ? 6'd24 : 6'd0);
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 3'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 3'd0;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step == 3'd5) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial products, registered, then accumulated; sign applied last
  always_ff @(posedge clk) begin
    if (start) begin
      a_q   <= a_mag;
      b_q   <= b_mag;
      neg_q <= neg;
      acc_q <= 100'd0;
    end else if (busy) begin
      if (step < 3'd4) begin
        pp   <= 50'(a_part) * 50'(b_part);
        sh_q <= shift;
      end
      if (step >= 3'd1 && step <= 3'd4) begin
        acc_q <= acc_q + (100'(pp) << sh_q);
      end
      if (step == 3'd5 && neg_q) begin
        acc_q <= 100'd0 - acc_q;
      end
    end
  end

  assign prod = acc_q;

endmodule

/* src/gso_root.sv */
// Shared bit-serial unit: integer square root of a 98-bit value, or a
// Q.30 quotient of a 48-bit magnitude by a 49-bit divisor. Uses gso_pkg.
module gso_root (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  gso_pkg::gso_op_t  op,
  input  logic [97:0]       radicand,
  input  logic [47:0]       dividend,
  input  logic [48:0]       divisor,
  output logic              done,
  output logic [48:0]       result
);

  logic             busy;
  logic [5:0]       cnt;
  gso_pkg::gso_op_t op_q;
  logic [53:0]      rem;
  logic [97:0]      src;
  logic [48:0]      res;
  logic [48:0]      dvs;
  logic [53:0]      rem_sh;
  logic [53:0]      sub;
  logic [54:0]      diff;
  logic             fits;

  // One digit: compare the shifted remainder against trial or divisor
  always_comb begin
    if (op_q == gso_pkg::OP_SQRT) begin
      rem_sh = {rem[51:0], src[97:96]};
      sub    = {3'b0, res, 2'b01};
    end else begin
      rem_sh = {rem[52:0], src[97]};
      sub    = {5'b0, dvs};
    end
    diff = {1'b0, rem_sh} - {1'b0, sub};
    fits = ~diff[54];
  end

  // Iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= (op == gso_pkg::OP_SQRT) ? 6'd48 : 6'd30;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder, source bits and result digits
  always_ff @(posedge clk) begin
    if (start) begin
      op_q <= op;
      dvs  <= divisor;
      res  <= 49'd0;
      if (op == gso_pkg::OP_SQRT) begin
        rem <= 54'd0;
        src <= radicand;
      end else begin
        rem <= 54'(dividend[47:1]);
        src <= {dividend[0], 97'd0};
      end
    end else if (busy) begin
      rem <= fits ? diff[53:0] : rem_sh;
      res <= {res[47:0], fits};
      src <= (op_q == gso_pkg::OP_SQRT) ? {src[95:0], 2'b00} : {src[96:0], 1'b0};
    end
  end

  assign result = res;

endmodule

/* src/gram_schmidt_orthonormalizer.sv */
// Modified Gram-Schmidt orthonormaliser: top level with load, sequencer and output.
// Depends on gso_pkg, gso_ram, gso_mul and gso_root.
//
// Usage: set rows_in_use and cols_in_use over the cfg channel (index 0, 1)
// while idle. Send the matrix in column-major order on the element channel,
// one beat per element, signed Q16.16; the beat with last_element high starts
// the work. Positions not loaded count as zero; beats past rows*cols are
// dropped. The result channel then gives rows*cols beats of Q1.30, saturated,
// column-major, with last_result on the final one.
// Loading accepts one element per cycle. Per column the sequencer walks the
// matrix store, one entry at a time through its single read port: each squared
// or dot-product term and each projection update is a read plus a pass of the
// multiplier, the root is one pass of the bit-serial root/divide unit, and each
// normalised element is a read plus a divide pass on that unit. Each output
// beat is read from the store before it is loaded into the output register. The
// element channel is stalled from the last beat until the final result sits in
// the output register.
// Reset clears the sequencer and sets both sizes to 8; a stalled result holds.
module gram_schmidt_orthonormalizer #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [3:0]         cfg_data,
  input  logic               elem_valid,
  output logic               elem_stall,
  input  logic signed [31:0] element_value,
  input  logic               last_element,
  output logic               res_valid,
  input  logic               res_stall,
  output logic signed [31:0] result_value,
  output logic               last_result
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int RW    = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;

  gso_pkg::gso_state_t state, state_next, state_prev;

  logic [3:0]  rows_reg, cols_reg, rows_eff, cols_eff, rows_l, cols_l;
  logic [6:0]  load_count, total_now, total_l, k;
  logic [7:0]  total_full;
  logic [CW-1:0] i, j;
  logic [RW-1:0] r;
  logic [99:0] acc, sum_next;
  logic [48:0] norm;
  logic [51:0] dot, dot_mag;
  logic signed [31:0] ucol [MAX_ROWS];

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [47:0]   ram_wdata, rd, rd_mag;
  logic [47:0]   ram_rdata_w;

  logic        mul_start, mul_neg, mul_done;
  logic [51:0] mul_a;
  logic [47:0] mul_b;
  logic [99:0] mul_prod;

  logic              root_start, root_done;
  gso_pkg::gso_op_t  root_op;
  logic [48:0]       root_res;

  logic        fresh, take, out_free, out_load;
  logic        last_r, last_i, last_j, k_last;
  logic [6:0]  c_ld, r_ld, c_k, r_k;
  logic [31:0] uc, uc_mag, q32, unit_v;
  logic [53:0] diff;
  logic [47:0] upd_v;
  logic [31:0] out_v;

  function automatic logic [AW-1:0] addr_of(input logic [6:0] c, input logic [6:0] rr);
    logic [9:0] t;
    t = 10'(c) * 10'(MAX_ROWS) + 10'(rr);
    return t[AW-1:0];
  endfunction

  // Effective sizes: zero acts as one, large values clamp to the maximum
  always_comb begin
    if (rows_reg == 4'd0)                rows_eff = 4'd1;
    else if (rows_reg > 4'(MAX_ROWS))    rows_eff = 4'(MAX_ROWS);
    else                                 rows_eff = rows_reg;
    if (cols_reg == 4'd0)                cols_eff = 4'd1;
    else if (cols_reg > 4'(MAX_COLS))    cols_eff = 4'(MAX_COLS);
    else                                 cols_eff = cols_reg;
    total_full = 8'(rows_eff) * 8'(cols_eff);
    total_now  = total_full[6:0];
  end

  // Positions of the load pointer and the sweep pointer
  always_comb begin
    c_ld = gso_pkg::div_small(load_count, rows_eff);
    r_ld = load_count - 7'(c_ld * 7'(rows_eff));
    c_k  = gso_pkg::div_small(k, rows_l);
    r_k  = k - 7'(c_k * 7'(rows_l));
  end

  // Loop ends and shared datapath terms
  always_comb begin
    fresh    = state != state_prev;
    take     = elem_valid && !elem_stall;
    out_free = !res_valid || !res_stall;
    last_r   = r == RW'(rows_l - 4'd1);
    last_i   = i == CW'(cols_l - 4'd1);
    last_j   = j == CW'(cols_l - 4'd1);
    k_last   = k == total_l - 7'd1;
    rd       = ram_rdata_w;
    rd_mag   = rd[47] ? 48'd0 - rd : rd;
    uc       = ucol[r];
    uc_mag   = uc[31] ? 32'd0 - uc : uc;
    dot_mag  = dot[51] ? 52'd0 - dot : dot;
    sum_next = acc + mul_prod;
    q32      = {1'b0, root_res[30:0]};
    unit_v   = rd[47] ? 32'd0 - q32 : q32;
    diff     = {{6{rd[47]}}, rd} - {mul_prod[82], mul_prod[82:30]};
    if (!diff[53] && (|diff[52:47]))      upd_v = {1'b0, {47{1'b1}}};
    else if (diff[53] && !(&diff[52:47])) upd_v = {1'b1, 47'd0};
    else                                  upd_v = diff[47:0];
    if (!rd[47] && (|rd[46:31]))          out_v = {1'b0, {31{1'b1}}};
    else if (rd[47] && !(&rd[46:31]))     out_v = {1'b1, 31'd0};
    else                                  out_v = rd[31:0];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      gso_pkg::ST_LOAD:   if (take && last_element) state_next = gso_pkg::ST_FILL;
      gso_pkg::ST_FILL:   if (k >= total_l) state_next = gso_pkg::ST_SQ_RD;
      gso_pkg::ST_SQ_RD:  state_next = gso_pkg::ST_SQ_WT;
      gso_pkg::ST_SQ_WT: begin
        if (mul_done) state_next = last_r ? gso_pkg::ST_ROOT : gso_pkg::ST_SQ_RD;
      end
      gso_pkg::ST_ROOT: begin
        if (root_done) begin
          if (root_res != 49'd0) state_next = gso_pkg::ST_NRM_RD;
          else state_next = last_i ? gso_pkg::ST_OUT_RD : gso_pkg::ST_DOT_RD;
        end
      end
      gso_pkg::ST_NRM_RD: state_next = gso_pkg::ST_NRM_WT;
      gso_pkg::ST_NRM_WT: begin
        if (root_done) begin
          if (!last_r) state_next = gso_pkg::ST_NRM_RD;
          else state_next = last_i ? gso_pkg::ST_OUT_RD : gso_pkg::ST_DOT_RD;
        end
      end
      gso_pkg::ST_DOT_RD: state_next = gso_pkg::ST_DOT_WT;
      gso_pkg::ST_DOT_WT: begin
        if (mul_done) state_next = last_r ? gso_pkg::ST_UPD_RD : gso_pkg::ST_DOT_RD;
      end
      gso_pkg::ST_UPD_RD: state_next = gso_pkg::ST_UPD_WT;
      gso_pkg::ST_UPD_WT: begin
        if (mul_done) begin
          if (!last_r) state_next = gso_pkg::ST_UPD_RD;
          else state_next = last_j ? gso_pkg::ST_SQ_RD : gso_pkg::ST_DOT_RD;
        end
      end
      gso_pkg::ST_OUT_RD: state_next = gso_pkg::ST_OUT_WT;
      gso_pkg::ST_OUT_WT: begin
        if (out_free) state_next = k_last ? gso_pkg::ST_LOAD : gso_pkg::ST_OUT_RD;
      end
      default: state_next = gso_pkg::ST_LOAD;
    endcase
  end

  // Memory, unit and handshake controls
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = addr_of(c_ld, r_ld);
    ram_wdata  = {{2{element_value[31]}}, element_value, 14'd0};
    ram_re     = 1'b0;
    ram_raddr  = addr_of(7'(i), 7'(r));
    mul_start  = 1'b0;
    mul_a      = 52'(rd_mag);
    mul_b      = rd_mag;
    mul_neg    = 1'b0;
    root_start = 1'b0;
    root_op    = gso_pkg::OP_SQRT;
    elem_stall = state != gso_pkg::ST_LOAD;
    out_load   = 1'b0;
    unique case (state)
      gso_pkg::ST_LOAD: ram_we = take && (load_count < total_now);
      gso_pkg::ST_FILL: begin
        ram_we    = k < total_l;
        ram_waddr = addr_of(c_k, r_k);
        ram_wdata = 48'd0;
      end
      gso_pkg::ST_SQ_RD, gso_pkg::ST_NRM_RD: ram_re = 1'b1;
      gso_pkg::ST_SQ_WT: mul_start = fresh;
      gso_pkg::ST_ROOT:  root_start = fresh;
      gso_pkg::ST_NRM_WT: begin
        root_start = fresh;
        root_op    = gso_pkg::OP_DIV;
        ram_we     = root_done;
        ram_waddr  = addr_of(7'(i), 7'(r));
        ram_wdata  = {{16{unit_v[31]}}, unit_v};
      end
      gso_pkg::ST_DOT_RD, gso_pkg::ST_UPD_RD: begin
        ram_re    = 1'b1;
        ram_raddr = addr_of(7'(j), 7'(r));
      end
      gso_pkg::ST_DOT_WT: begin
        mul_start = fresh;
        mul_b     = 48'(uc_mag);
        mul_neg   = rd[47] ^ uc[31];
      end
      gso_pkg::ST_UPD_WT: begin
        mul_start = fresh;
        mul_a     = dot_mag;
        mul_b     = 48'(uc_mag);
        mul_neg   = dot[51] ^ uc[31];
        ram_we    = mul_done;
        ram_waddr = addr_of(7'(j), 7'(r));
        ram_wdata = upd_v;
      end
      gso_pkg::ST_OUT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = addr_of(c_k, r_k);
      end
      gso_pkg::ST_OUT_WT: out_load = out_free;
      default: ram_we = 1'b0;
    endcase
  end

  assign cfg_ready = 1'b1;

  // Control state: sequencer, sizes, load count, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= gso_pkg::ST_LOAD;
      state_prev <= gso_pkg::ST_LOAD;
      rows_reg   <= 4'd8;
      cols_reg   <= 4'd8;
      load_count <= 7'd0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      state_prev <= state;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == gso_pkg::CFG_ROWS) rows_reg <= cfg_data;
        if (cfg_index == gso_pkg::CFG_COLS) cols_reg <= cfg_data;
      end
      if (state == gso_pkg::ST_LOAD && take) begin
        if (last_element)               load_count <= 7'd0;
        else if (load_count < total_now) load_count <= load_count + 7'd1;
      end
      if (out_load)        res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
    end
  end

  // Counters and working registers
  always_ff @(posedge clk) begin
    unique case (state)
      gso_pkg::ST_LOAD: begin
        if (take && last_element) begin
          rows_l  <= rows_eff;
          cols_l  <= cols_eff;
          total_l <= total_now;
          k       <= (load_count < total_now) ? load_count + 7'd1 : load_count;
        end
      end
      gso_pkg::ST_FILL: begin
        if (k < total_l) begin
          k <= k + 7'd1;
        end else begin
          i   <= '0;
          r   <= '0;
          acc <= 100'd0;
        end
      end
      gso_pkg::ST_SQ_WT: begin
        if (mul_done) begin
          acc <= sum_next;
          r   <= last_r ? '0 : r + RW'(1);
        end
      end
      gso_pkg::ST_ROOT: begin
        if (root_done) begin
          norm <= root_res;
          if (root_res == 49'd0) begin
            for (int n = 0; n < MAX_ROWS; n++) ucol[n] <= 32'sd0;
            j   <= i + CW'(1);
            acc <= 100'd0;
            k   <= 7'd0;
          end
        end
      end
      gso_pkg::ST_NRM_WT: begin
        if (root_done) begin
          ucol[r] <= unit_v;
          r       <= last_r ? '0 : r + RW'(1);
          if (last_r) begin
            j   <= i + CW'(1);
            acc <= 100'd0;
            k   <= 7'd0;
          end
        end
      end
      gso_pkg::ST_DOT_WT: begin
        if (mul_done) begin
          acc <= sum_next;
          r   <= last_r ? '0 : r + RW'(1);
          if (last_r) dot <= sum_next[81:30];
        end
      end
      gso_pkg::ST_UPD_WT: begin
        if (mul_done) begin
          r <= last_r ? '0 : r + RW'(1);
          if (last_r) begin
            acc <= 100'd0;
            if (last_j) i <= i + CW'(1);
            else        j <= j + CW'(1);
          end
        end
      end
      gso_pkg::ST_OUT_WT: begin
        if (out_free) begin
          k            <= k + 7'd1;
          result_value <= out_v;
          last_result  <= k_last;
        end
      end
      default: k <= k;
    endcase
  end

  gso_ram #(
    .WIDTH (48),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata_w)
  );

  gso_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a_mag (mul_a),
    .b_mag (mul_b),
    .neg   (mul_neg),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  gso_root u_root (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .op       (root_op),
    .radicand (acc[97:0]),
    .dividend (rd_mag),
    .divisor  (norm),
    .done     (root_done),
    .result   (root_res)
  );

endmodule
